// ----- rtl/core/gwbf_pkg.sv -----
// Shared types and constants for the generational write-barrier filter.
package gwbf_pkg;

    localparam int AddrBits        = 48;
    localparam int DataBits        = 64;
    localparam int CountBits       = 7;
    localparam int CfgIndexBits    = 2;
    localparam int SetDepthDefault = 64;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_OLD_BASE   = 2'd0,
        CFG_OLD_END    = 2'd1,
        CFG_YOUNG_BASE = 2'd2,
        CFG_YOUNG_END  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EVAL   = 2'd1,
        ST_SCAN   = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    typedef struct packed {
        logic                command;
        logic [AddrBits-1:0] slot_address;
        logic [DataBits-1:0] store_data;
    } gwbf_req_t;

    typedef struct packed {
        logic                 store_enable;
        logic [AddrBits-1:0]  store_address;
        logic [DataBits-1:0]  store_value;
        logic                 slot_added;
        logic                 set_overflow;
        logic [CountBits-1:0] entry_count;
    } gwbf_rsp_t;

    typedef struct packed {
        logic [AddrBits-1:0] old_base;
        logic [AddrBits-1:0] old_end;
        logic [AddrBits-1:0] young_base;
        logic [AddrBits-1:0] young_end;
    } cfg_regs_t;

    // Search token moving along the row of cells
    typedef struct packed {
        logic tok;
        logic hit;
    } chain_sts_t;

    // Controller commands to the row of cells
    typedef struct packed {
        logic launch;
        logic shift;
    } chain_ctl_t;

endpackage

// ----- rtl/core/gwbf_cell.sv -----
// One remembered-set cell: holds one slot, checks the passing token, shifts on insert.
module gwbf_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gwbf_pkg::AddrBits-1:0] key,
    input  logic [CNT_W-1:0]              count,
    input  logic                          shift,
    input  logic [gwbf_pkg::AddrBits-1:0] slot_in,
    output logic [gwbf_pkg::AddrBits-1:0] slot_out,
    input  gwbf_pkg::chain_sts_t          sts_in,
    output gwbf_pkg::chain_sts_t          sts_out
);
    import gwbf_pkg::*;

    logic [AddrBits-1:0] slot_reg;
    logic                tok_reg;
    logic                hit_reg;
    logic                occupied;
    logic                match;

    // Cell holds a live entry only below the fill count
    assign occupied = (count > CNT_W'(INDEX));
    assign match    = occupied && (slot_reg == key);

    // Advance the token and fold in this cell's match
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= sts_in.tok;
            hit_reg <= sts_in.tok && (sts_in.hit || match);
        end
    end

    // Take the neighbor's slot on insert
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            slot_reg <= slot_in;
        end
    end

    assign slot_out    = slot_reg;
    assign sts_out.tok = tok_reg;
    assign sts_out.hit = hit_reg;

endmodule

// ----- rtl/core/gwbf_ctrl.sv -----
// Request sequencer: range filter, search launch, insert decision and result register.
module gwbf_ctrl #(
    parameter int SET_DEPTH = gwbf_pkg::SetDepthDefault,
    localparam int CNT_W = $clog2(SET_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gwbf_pkg::gwbf_req_t           in_req,
    output logic                          out_valid,
    input  logic                          out_ready,
    output gwbf_pkg::gwbf_rsp_t           out_rsp,
    input  gwbf_pkg::cfg_regs_t           cfg,
    output logic [CNT_W-1:0]              count,
    output logic [gwbf_pkg::AddrBits-1:0] key,
    output gwbf_pkg::chain_ctl_t          chain_ctl,
    input  gwbf_pkg::chain_sts_t          chain_sts
);
    import gwbf_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    gwbf_req_t  req_reg;
    logic       hit_reg;
    logic       hit_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic       out_valid_reg;
    gwbf_rsp_t  out_rsp_reg;
    gwbf_rsp_t  rsp_next;
    logic       out_load;
    logic       out_free;
    logic       is_clear;
    logic       is_drop;
    logic       slot_old;
    logic       data_young;
    logic       candidate;
    logic [DataBits-1:0] young_lo;
    logic [DataBits-1:0] young_hi;

    assign out_free = !out_valid_reg || out_ready;

    // Classify the held request
    assign is_clear   = (req_reg.command == CMD_CLEAR);
    assign is_drop    = (req_reg.slot_address == '0) || (req_reg.store_data == '0);
    assign young_lo   = DataBits'(cfg.young_base);
    assign young_hi   = DataBits'(cfg.young_end);
    assign slot_old   = (req_reg.slot_address >= cfg.old_base) &&
                        (req_reg.slot_address <  cfg.old_end);
    assign data_young = (req_reg.store_data >= young_lo) &&
                        (req_reg.store_data <  young_hi);
    assign candidate  = slot_old && data_young;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!is_clear && !is_drop && candidate)
                begin
                    state_next = ST_SCAN;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (chain_sts.tok)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs: result, count update, chain commands
    always_comb
    begin
        out_load   = 1'b0;
        rsp_next   = '0;
        count_next = count_reg;
        hit_next   = hit_reg;
        chain_ctl  = '0;
        case (state_reg)
            ST_EVAL:
            begin
                if (is_clear)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        count_next = '0;
                    end
                end
                else if (is_drop)
                begin
                    out_load             = out_free;
                    rsp_next.entry_count = CountBits'(count_reg);
                end
                else if (!candidate)
                begin
                    out_load               = out_free;
                    rsp_next.store_enable  = 1'b1;
                    rsp_next.store_address = req_reg.slot_address;
                    rsp_next.store_value   = req_reg.store_data;
                    rsp_next.entry_count   = CountBits'(count_reg);
                end
                else
                begin
                    chain_ctl.launch = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (chain_sts.tok)
                begin
                    hit_next = chain_sts.hit;
                end
            end
            ST_FINISH:
            begin
                rsp_next.store_enable  = 1'b1;
                rsp_next.store_address = req_reg.slot_address;
                rsp_next.store_value   = req_reg.store_data;
                rsp_next.entry_count   = CountBits'(count_reg);
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (!hit_reg)
                    begin
                        if (count_reg < CNT_W'(SET_DEPTH))
                        begin
                            chain_ctl.shift      = 1'b1;
                            count_next           = count_reg + CNT_W'(1);
                            rsp_next.slot_added  = 1'b1;
                            rsp_next.entry_count = CountBits'(count_next);
                        end
                        else
                        begin
                            rsp_next.set_overflow = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hit_reg   <= hit_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold request and result payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
        if (out_load)
        begin
            out_rsp_reg <= rsp_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;
    assign count     = count_reg;
    assign key       = req_reg.slot_address;

    // Fill count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SET_DEPTH))
    else $error("remembered set count above capacity");

    // A result never reports both an insertion and an overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_rsp_reg.slot_added && out_rsp_reg.set_overflow))
    else $error("slot_added and set_overflow both set");

    // An insertion grows the count by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_ctl.shift |=> count_reg == $past(count_reg) + CNT_W'(1))
    else $error("insert did not advance the count");

    // The token leaving the row ends the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && chain_sts.tok) |=> state_reg == ST_FINISH)
    else $error("scan did not finish on token arrival");

    // Launch only from evaluation, never during a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_ctl.launch |-> state_reg == ST_EVAL)
    else $error("search launched outside evaluation");

endmodule

// ----- rtl/core/generational_write_barrier_filter.sv -----
// Top level: range registers, the row of remembered-set cells and the sequencer.
// A request is taken whenever the block is idle, even while a finished result
// still waits in the output register. A clear, a null or zero-valued store, or a
// store outside the old-to-young ranges is done after accept and evaluate, with
// evaluate held until the output register is free. A store that crosses from old
// to young walks a search token through all SET_DEPTH cells, one cell per cycle,
// then inserts by shifting the row unless the slot is held or the set is full.
// The set needs no clearing pass after reset: the fill count marks live cells.
// Range registers are written through the cfg port, index 0 old_base, 1 old_end,
// 2 young_base, 3 young_end; an empty or inverted range matches nothing.
module generational_write_barrier_filter #(
    parameter int SET_DEPTH = gwbf_pkg::SetDepthDefault
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  gwbf_pkg::gwbf_req_t               in_req,
    output logic                              out_valid,
    input  logic                              out_ready,
    output gwbf_pkg::gwbf_rsp_t               out_rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gwbf_pkg::CfgIndexBits-1:0] cfg_index,
    input  logic [gwbf_pkg::AddrBits-1:0]     cfg_data
);
    import gwbf_pkg::*;

    localparam int CNT_W = $clog2(SET_DEPTH + 1);

    cfg_regs_t           cfg_reg;
    logic [CNT_W-1:0]    count;
    logic [AddrBits-1:0] key;
    chain_ctl_t          chain_ctl;
    chain_sts_t          chain_sts;
    logic [AddrBits-1:0] slot_src [SET_DEPTH];
    logic [AddrBits-1:0] slot_q   [SET_DEPTH];
    chain_sts_t          sts_src  [SET_DEPTH];
    chain_sts_t          sts_q    [SET_DEPTH];

    assign cfg_ready = 1'b1;

    // Write range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OLD_BASE:   cfg_reg.old_base   <= cfg_data;
                CFG_OLD_END:    cfg_reg.old_end    <= cfg_data;
                CFG_YOUNG_BASE: cfg_reg.young_base <= cfg_data;
                CFG_YOUNG_END:  cfg_reg.young_end  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    gwbf_ctrl #(
        .SET_DEPTH (SET_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp),
        .cfg       (cfg_reg),
        .count     (count),
        .key       (key),
        .chain_ctl (chain_ctl),
        .chain_sts (chain_sts)
    );

    // Build the row: new slots and the token both enter at cell zero
    for (genvar i = 0; i < SET_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign slot_src[i]    = key;
            assign sts_src[i].tok = chain_ctl.launch;
            assign sts_src[i].hit = 1'b0;
        end
        else
        begin : g_link
            assign slot_src[i] = slot_q[i-1];
            assign sts_src[i]  = sts_q[i-1];
        end

        gwbf_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (key),
            .count    (count),
            .shift    (chain_ctl.shift),
            .slot_in  (slot_src[i]),
            .slot_out (slot_q[i]),
            .sts_in   (sts_src[i]),
            .sts_out  (sts_q[i])
        );
    end

    assign chain_sts = sts_q[SET_DEPTH-1];

endmodule
